>>> src/gma_pkg.sv
// Shared types and constants for the greedy maximum assignment block.
package gma_pkg;

   localparam int SizeBits     = 5;
   localparam int CsrAddrBits  = 2;
   localparam int CsrDataBits  = 32;
   localparam int OutIdxBits   = 4;

   localparam logic [SizeBits-1:0]    SizeReset     = 5'd16;
   localparam logic [CsrAddrBits-1:0] RegMatrixSize = 2'd0;

   typedef struct packed {
      logic [OutIdxBits-1:0] row_index;
      logic [OutIdxBits-1:0] col_index;
      logic                  pair_found;
      logic                  last_pair;
   } result_type;

   typedef struct packed {
      logic busy;
      logic run_done;
   } back_status_type;

endpackage

>>> src/gma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gma_ram #(
   parameter  int WIDTH = 16,
   parameter  int DEPTH = 256,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [AW-1:0]        waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic                 re,
   input  logic [AW-1:0]        raddr,
   output logic [WIDTH-1:0]     rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule

>>> src/gma_fifo.sv
// Small generic FIFO built from registers.
module gma_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             full,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      full      = (count_ff == CW'(DEPTH));
      empty     = (count_ff == '0);
      do_push   = push && !full;
      do_pop    = pop && !empty;
      dout      = mem_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end
endmodule

>>> src/gma_front.sv
// Front end: size register, matrix loading and run launch.
module gma_front #(
   parameter  int MAX_SIZE   = 16,
   parameter  int SCORE_BITS = 16,
   localparam int Depth      = MAX_SIZE * MAX_SIZE,
   localparam int AW         = (Depth > 1) ? $clog2(Depth) : 1,
   localparam int NW         = $clog2(MAX_SIZE + 1),
   localparam int LW         = $clog2(Depth + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [gma_pkg::CsrAddrBits-1:0] csr_paddr,
   input  logic [gma_pkg::CsrDataBits-1:0] csr_pwdata,
   output logic [gma_pkg::CsrDataBits-1:0] csr_prdata,
   output logic                            csr_pready,
   input  logic                            req_push,
   input  logic signed [SCORE_BITS-1:0]    req_score,
   output logic                            req_full,
   output logic                            ram_we,
   output logic [AW-1:0]                   ram_waddr,
   output logic [SCORE_BITS-1:0]           ram_wdata,
   output logic                            cmd_push,
   output logic [NW-1:0]                   cmd_size,
   input  logic                            cmd_full,
   input  gma_pkg::back_status_type        status
);
   logic [gma_pkg::SizeBits-1:0] size_ff, size_in;
   logic [LW-1:0]                load_ff, load_in;
   logic                         hold_ff, hold_in;
   logic [NW-1:0]                n;
   logic [LW-1:0]                n_sq;
   logic [LW-1:0]                load_next;
   logic                         take, active, launch, csr_wr;

   always_comb begin
      if (32'(size_ff) > MAX_SIZE) begin
         n = NW'(MAX_SIZE);
      end else begin
         n = NW'(size_ff);
      end
      n_sq      = LW'(n) * LW'(n);
      req_full  = hold_ff || status.busy || cmd_full;
      take      = req_push && !req_full;
      // a zero size drops the word
      active    = take && (n != '0);
      load_next = load_ff + LW'(1);
      launch    = active && (load_next >= n_sq);

      ram_we    = active;
      ram_waddr = load_ff[AW-1:0];
      ram_wdata = req_score;
      cmd_push  = launch;
      cmd_size  = n;

      load_in = load_ff;
      if (launch) begin
         load_in = '0;
      end else if (active) begin
         load_in = load_next;
      end

      hold_in = hold_ff;
      if (launch) begin
         hold_in = 1'b1;
      end else if (status.run_done) begin
         hold_in = 1'b0;
      end

      csr_pready = 1'b1;
      csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr == gma_pkg::RegMatrixSize);
      size_in    = csr_wr ? csr_pwdata[gma_pkg::SizeBits-1:0] : size_ff;
      csr_prdata = (csr_paddr == gma_pkg::RegMatrixSize) ?
                   gma_pkg::CsrDataBits'(size_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= gma_pkg::SizeReset;
         load_ff <= '0;
         hold_ff <= 1'b0;
      end else begin
         size_ff <= size_in;
         load_ff <= load_in;
         hold_ff <= hold_in;
      end
   end
endmodule

>>> src/gma_back.sv
// Back end: round sequencer that scans the stored matrix and emits pairs.
module gma_back #(
   parameter  int MAX_SIZE   = 16,
   parameter  int SCORE_BITS = 16,
   localparam int Depth      = MAX_SIZE * MAX_SIZE,
   localparam int AW         = (Depth > 1) ? $clog2(Depth) : 1,
   localparam int NW         = $clog2(MAX_SIZE + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_empty,
   input  logic [NW-1:0]               cmd_size,
   output logic                        cmd_pop,
   output logic                        ram_re,
   output logic [AW-1:0]               ram_raddr,
   input  logic [SCORE_BITS-1:0]       ram_rdata,
   input  logic                        out_full,
   output logic                        out_push,
   output gma_pkg::result_type         out_word,
   output gma_pkg::back_status_type    status
);
   localparam int IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int OW    = gma_pkg::OutIdxBits;

   localparam logic signed [SCORE_BITS-1:0] NegOne = {3'b111, {(SCORE_BITS-3){1'b0}}};

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_DECIDE,
      S_CLOSE
   } state_type;

   state_type                     state_ff, state_in;
   logic [NW-1:0]                 n_ff, n_in;
   logic [NW-1:0]                 round_ff, round_in;
   logic [IW-1:0]                 i_ff, i_in, j_ff, j_in;
   logic [AW-1:0]                 addr_ff, addr_in;
   logic signed [SCORE_BITS-1:0]  best_ff, best_in;
   logic                          found_ff, found_in;
   logic [IW-1:0]                 bi_ff, bi_in, bj_ff, bj_in;
   logic                          pend_ff, pend_in;
   logic [OW-1:0]                 pend_row_ff, pend_row_in, pend_col_ff, pend_col_in;
   logic [MAX_SIZE-1:0]           row_taken_ff, row_taken_in;
   logic [MAX_SIZE-1:0]           col_taken_ff, col_taken_in;
   logic                          rv_ff, rv_in, skip_ff, skip_in;
   logic [IW-1:0]                 ri_ff, ri_in, rj_ff, rj_in;
   logic                          hit, j_last, i_last;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      round_in     = round_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      addr_in      = addr_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      bi_in        = bi_ff;
      bj_in        = bj_ff;
      pend_in      = pend_ff;
      pend_row_in  = pend_row_ff;
      pend_col_in  = pend_col_ff;
      row_taken_in = row_taken_ff;
      col_taken_in = col_taken_ff;
      rv_in        = 1'b0;
      skip_in      = skip_ff;
      ri_in        = ri_ff;
      rj_in        = rj_ff;
      cmd_pop      = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = addr_ff;
      out_push     = 1'b0;
      out_word     = '0;
      status.busy     = (state_ff != S_IDLE);
      status.run_done = 1'b0;

      j_last = (NW'(j_ff) + NW'(1)) == n_ff;
      i_last = (NW'(i_ff) + NW'(1)) == n_ff;

      // strict compare keeps the first entry on a tie
      hit = rv_ff && !skip_ff && ($signed(ram_rdata) > best_ff);
      if (hit) begin
         best_in  = $signed(ram_rdata);
         bi_in    = ri_ff;
         bj_in    = rj_ff;
         found_in = 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               n_in     = cmd_size;
               round_in = '0;
               i_in     = '0;
               j_in     = '0;
               addr_in  = '0;
               best_in  = NegOne;
               found_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            ram_re  = 1'b1;
            rv_in   = 1'b1;
            skip_in = row_taken_ff[i_ff] | col_taken_ff[j_ff];
            ri_in   = i_ff;
            rj_in   = j_ff;
            addr_in = addr_ff + AW'(1);
            if (j_last) begin
               j_in = '0;
               i_in = i_ff + IW'(1);
               if (i_last) begin
                  state_in = S_DRAIN;
               end
            end else begin
               j_in = j_ff + IW'(1);
            end
         end
         S_DRAIN: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!found_ff) begin
               state_in = S_CLOSE;
            end else if (!(pend_ff && out_full)) begin
               // release the previous pair, hold this one until the next round ends
               if (pend_ff) begin
                  out_push = 1'b1;
                  out_word = '{row_index: pend_row_ff, col_index: pend_col_ff,
                               pair_found: 1'b1, last_pair: 1'b0};
               end
               pend_in             = 1'b1;
               pend_row_in         = OW'(bi_ff);
               pend_col_in         = OW'(bj_ff);
               row_taken_in[bi_ff] = 1'b1;
               col_taken_in[bj_ff] = 1'b1;
               round_in            = round_ff + NW'(1);
               i_in                = '0;
               j_in                = '0;
               addr_in             = '0;
               best_in             = NegOne;
               found_in            = 1'b0;
               if ((round_ff + NW'(1)) == n_ff) begin
                  state_in = S_CLOSE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_CLOSE: begin
            if (!out_full) begin
               out_push = 1'b1;
               if (pend_ff) begin
                  out_word = '{row_index: pend_row_ff, col_index: pend_col_ff,
                               pair_found: 1'b1, last_pair: 1'b1};
               end else begin
                  out_word = '{row_index: '0, col_index: '0,
                               pair_found: 1'b0, last_pair: 1'b1};
               end
               pend_in         = 1'b0;
               row_taken_in    = '0;
               col_taken_in    = '0;
               status.run_done = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rv_ff        <= 1'b0;
         found_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         row_taken_ff <= '0;
         col_taken_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rv_ff        <= rv_in;
         found_ff     <= found_in;
         pend_ff      <= pend_in;
         row_taken_ff <= row_taken_in;
         col_taken_ff <= col_taken_in;
      end
      n_ff        <= n_in;
      round_ff    <= round_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      addr_ff     <= addr_in;
      best_ff     <= best_in;
      bi_ff       <= bi_in;
      bj_ff       <= bj_in;
      pend_row_ff <= pend_row_in;
      pend_col_ff <= pend_col_in;
      skip_ff     <= skip_in;
      ri_ff       <= ri_in;
      rj_ff       <= rj_in;
   end
endmodule

>>> src/greedy_max_assignment.sv
// Loading: one score word per cycle while req_full is low; an n by n matrix takes n*n
// words, none taken during a run. Run: up to n rounds, each one RAM read per entry, then
// drain and decide; each pair leaves one round after it is found, the last at the end.
// No new score word is taken until the run on the loaded matrix has closed.
// Reset (synchronous): matrix_size returns to 16, load count and flags clear; the
// score RAM keeps whatever it holds and needs no clearing.
module greedy_max_assignment #(
   parameter int MAX_SIZE   = 16,
   parameter int SCORE_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gma_pkg::CsrAddrBits-1:0]     csr_paddr,
   input  logic [gma_pkg::CsrDataBits-1:0]     csr_pwdata,
   output logic [gma_pkg::CsrDataBits-1:0]     csr_prdata,
   output logic                                csr_pready,
   input  logic                                req_push,
   input  logic signed [SCORE_BITS-1:0]        req_score,
   output logic                                req_full,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [gma_pkg::OutIdxBits-1:0]      rsp_row_index,
   output logic [gma_pkg::OutIdxBits-1:0]      rsp_col_index,
   output logic                                rsp_pair_found,
   output logic                                rsp_last_pair
);
   localparam int Depth = MAX_SIZE * MAX_SIZE;
   localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int NW    = $clog2(MAX_SIZE + 1);
   localparam int RW    = $bits(gma_pkg::result_type);

   logic                      ram_we, ram_re;
   logic [AW-1:0]             ram_waddr, ram_raddr;
   logic [SCORE_BITS-1:0]     ram_wdata, ram_rdata;
   logic                      cmd_push, cmd_pop, cmd_full, cmd_empty;
   logic [NW-1:0]             cmd_size_w, cmd_size_r;
   logic                      out_push, out_full;
   gma_pkg::result_type       out_word, rsp_word;
   logic [RW-1:0]             rsp_bits;
   gma_pkg::back_status_type  status;

   gma_front #(.MAX_SIZE(MAX_SIZE), .SCORE_BITS(SCORE_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_push    (req_push),
      .req_score   (req_score),
      .req_full    (req_full),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .cmd_push    (cmd_push),
      .cmd_size    (cmd_size_w),
      .cmd_full    (cmd_full),
      .status      (status)
   );

   gma_ram #(.WIDTH(SCORE_BITS), .DEPTH(Depth)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   gma_fifo #(.WIDTH(NW), .DEPTH(2)) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .din   (cmd_size_w),
      .pop   (cmd_pop),
      .dout  (cmd_size_r),
      .full  (cmd_full),
      .empty (cmd_empty)
   );

   gma_back #(.MAX_SIZE(MAX_SIZE), .SCORE_BITS(SCORE_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_size  (cmd_size_r),
      .cmd_pop   (cmd_pop),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_word  (out_word),
      .status    (status)
   );

   gma_fifo #(.WIDTH(RW), .DEPTH(4)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .din   (out_word),
      .pop   (rsp_pop),
      .dout  (rsp_bits),
      .full  (out_full),
      .empty (rsp_empty)
   );

   assign rsp_word       = gma_pkg::result_type'(rsp_bits);
   assign rsp_row_index  = rsp_word.row_index;
   assign rsp_col_index  = rsp_word.col_index;
   assign rsp_pair_found = rsp_word.pair_found;
   assign rsp_last_pair  = rsp_word.last_pair;
endmodule

>>> src/gma_checker.sv
// Port-level checks on the result channel, bound to the top level.
module gma_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_empty,
   input logic                           rsp_pop,
   input logic [gma_pkg::OutIdxBits-1:0] rsp_row_index,
   input logic [gma_pkg::OutIdxBits-1:0] rsp_col_index,
   input logic                           rsp_pair_found,
   input logic                           rsp_last_pair
);
   // nothing waits right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result word visible right after reset");

   // a word without a pair closes its run
   a_nopair_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pair_found) |-> rsp_last_pair)
      else $error("no-pair word not marked last");

   a_nopair_zero_idx: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pair_found) |-> (rsp_row_index == '0 && rsp_col_index == '0))
      else $error("no-pair word carries nonzero indices");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_row_index) && $stable(rsp_col_index) &&
          $stable(rsp_pair_found) && $stable(rsp_last_pair)))
      else $error("waiting result word changed or vanished");
endmodule

bind greedy_max_assignment gma_checker u_gma_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_row_index  (rsp_row_index),
   .rsp_col_index  (rsp_col_index),
   .rsp_pair_found (rsp_pair_found),
   .rsp_last_pair  (rsp_last_pair)
);

>>> tb/greedy_max_assignment_test.sv
// Self-checking testbench for greedy_max_assignment: predicts every run's pairs and checks them.
module greedy_max_assignment_test;

   localparam int MaxSize      = 16;
   localparam int ScoreBits    = 16;
   localparam int StoreDepth   = MaxSize * MaxSize;
   localparam int NegOne       = -(1 << (ScoreBits - 3));
   localparam int HoldOff      = 400;
   localparam int SettleCycles = 40;
   localparam int CycleLimit   = 400000;

   typedef enum {FillWide, FillTies, FillBelow} fill_kind_type;

   class greedy_pairs_type;
      logic [gma_pkg::SizeBits-1:0] size_reg;
      logic signed [ScoreBits-1:0]  scores [StoreDepth];
      int unsigned                  loaded;
      gma_pkg::result_type          pairs_due [$];
      int                           errors;
      int                           taken;
      int                           seen;

      function new();
         size_reg = gma_pkg::SizeReset;
         loaded   = 0;
         errors   = 0;
         taken    = 0;
         seen     = 0;
         foreach (scores[k]) scores[k] = '0;
      endfunction

      function void write_size(logic [gma_pkg::CsrDataBits-1:0] value);
         size_reg = value[gma_pkg::SizeBits-1:0];
      endfunction

      function int outstanding();
         return pairs_due.size();
      endfunction

      // Greedy rounds over the loaded n by n block; row and column marks are local to one run.
      function void solve_matrix(int n);
         logic [MaxSize-1:0]  rows_used;
         logic [MaxSize-1:0]  cols_used;
         gma_pkg::result_type fresh [$];
         gma_pkg::result_type pick;
         int                  best;
         int                  cand;
         int                  bi;
         int                  bj;
         bit                  hit;
         rows_used = '0;
         cols_used = '0;
         for (int pass_no = 0; pass_no < n; pass_no++) begin
            best = NegOne;
            hit  = 1'b0;
            bi   = 0;
            bj   = 0;
            for (int i = 0; i < n; i++) begin
               if (rows_used[i]) continue;
               for (int j = 0; j < n; j++) begin
                  if (cols_used[j]) continue;
                  cand = scores[(i * n + j) % StoreDepth];
                  // strictly greater: the first entry in scan order keeps a tie
                  if (cand > best) begin
                     best = cand;
                     bi   = i;
                     bj   = j;
                     hit  = 1'b1;
                  end
               end
            end
            if (hit) begin
               rows_used[bi]  = 1'b1;
               cols_used[bj]  = 1'b1;
               pick.row_index  = bi[gma_pkg::OutIdxBits-1:0];
               pick.col_index  = bj[gma_pkg::OutIdxBits-1:0];
               pick.pair_found = 1'b1;
               pick.last_pair  = 1'b0;
               fresh[fresh.size()] = pick;
            end
         end
         if (fresh.size() == 0) begin
            pick           = '0;
            pick.last_pair = 1'b1;
            fresh[fresh.size()] = pick;
         end else begin
            fresh[fresh.size()-1].last_pair = 1'b1;
         end
         foreach (fresh[k]) pairs_due[pairs_due.size()] = fresh[k];
      endfunction

      function void note_score(logic signed [ScoreBits-1:0] s);
         int n;
         n = (size_reg > MaxSize) ? MaxSize : int'(size_reg);
         taken++;
         if (n == 0) return;
         scores[loaded % StoreDepth] = s;
         if (loaded < StoreDepth) loaded++;
         if (loaded < n * n) return;
         solve_matrix(n);
         loaded = 0;
      endfunction

      function void compare_field(string name, logic [3:0] want, logic [3:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_pair(logic [3:0] row, logic [3:0] col, logic found, logic last);
         gma_pkg::result_type want;
         seen++;
         if (pairs_due.size() == 0) begin
            $error("result word with nothing expected: row %0d col %0d found %0b last %0b",
                   row, col, found, last);
            errors++;
            return;
         end
         want = pairs_due.pop_front();
         compare_field("row_index", want.row_index, row);
         compare_field("col_index", want.col_index, col);
         compare_field("pair_found", 4'(want.pair_found), 4'(found));
         compare_field("last_pair", 4'(want.last_pair), 4'(last));
      endfunction
   endclass

   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                csr_psel    = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite  = 1'b0;
   logic [gma_pkg::CsrAddrBits-1:0]     csr_paddr   = gma_pkg::RegMatrixSize;
   logic [gma_pkg::CsrDataBits-1:0]     csr_pwdata  = '0;
   logic [gma_pkg::CsrDataBits-1:0]     csr_prdata;
   logic                                csr_pready;
   logic                                req_push    = 1'b0;
   logic signed [ScoreBits-1:0]         req_score   = '0;
   logic                                req_full;
   logic                                rsp_empty;
   logic                                rsp_pop     = 1'b0;
   logic [gma_pkg::OutIdxBits-1:0]      rsp_row_index;
   logic [gma_pkg::OutIdxBits-1:0]      rsp_col_index;
   logic                                rsp_pair_found;
   logic                                rsp_last_pair;

   bit               calm             = 1'b0;
   bit               hold_off_request = 1'b0;
   int               size_writes      = 0;
   int unsigned      cycle_count      = 0;
   greedy_pairs_type board            = new();

   greedy_max_assignment #(
      .MAX_SIZE(MaxSize),
      .SCORE_BITS(ScoreBits)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .req_push(req_push),
      .req_score(req_score),
      .req_full(req_full),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_row_index(rsp_row_index),
      .rsp_col_index(rsp_col_index),
      .rsp_pair_found(rsp_pair_found),
      .rsp_last_pair(rsp_last_pair)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("greedy_max_assignment: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         board.check_pair(rsp_row_index, rsp_col_index, rsp_pair_found, rsp_last_pair);
   end

   // Result side: random stalls, one long hold-off on request, steady pop when calm.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_pop <= 1'b0;
            repeat (HoldOff - 1) @(negedge clock);
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 17) - 1) @(negedge clock);
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   task automatic sender_idle(int cycles);
      @(negedge clock);
      req_push <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Leaves push high after the accepting edge; the next call or an idle moves it.
   task automatic send_score(int s);
      logic signed [ScoreBits-1:0] word_bits;
      word_bits = ScoreBits'(s);
      if (!calm && $urandom_range(0, 5) == 0) sender_idle($urandom_range(1, 17));
      @(negedge clock);
      req_push  <= 1'b1;
      req_score <= word_bits;
      do @(posedge clock); while (req_full);
      board.note_score(word_bits);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_push <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_cycle(bit wr, logic [gma_pkg::CsrDataBits-1:0] wdata,
                            output logic [gma_pkg::CsrDataBits-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= gma_pkg::RegMatrixSize;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
   endtask

   task automatic set_size(logic [gma_pkg::CsrDataBits-1:0] value);
      logic [gma_pkg::CsrDataBits-1:0] readback;
      wait_idle();
      csr_cycle(1'b1, value, readback);
      board.write_size(value);
      csr_cycle(1'b0, '0, readback);
      if (readback !== gma_pkg::CsrDataBits'(value[gma_pkg::SizeBits-1:0])) begin
         $error("matrix_size readback: expected %0d, got %0d",
                value[gma_pkg::SizeBits-1:0], readback);
         board.errors++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      size_writes++;
   endtask

   function automatic logic signed [ScoreBits-1:0] draw_score(fill_kind_type kind);
      int v;
      case (kind)
         FillBelow: begin
            case ($urandom_range(0, 3))
               0:       v = NegOne;
               1:       v = -32768;
               default: v = int'($urandom_range(0, 32768 + NegOne)) - 32768;
            endcase
         end
         FillTies: begin
            case ($urandom_range(0, 3))
               0:       v = NegOne;
               1:       v = NegOne + 1;
               2:       v = 0;
               default: v = 32767;
            endcase
         end
         default: begin
            if ($urandom_range(0, 15) == 0) begin
               case ($urandom_range(0, 3))
                  0:       v = 32767;
                  1:       v = -32768;
                  2:       v = NegOne;
                  default: v = NegOne + 1;
               endcase
            end else begin
               v = int'($urandom() & 32'hFFFF);
            end
         end
      endcase
      return v[ScoreBits-1:0];
   endfunction

   task automatic send_matrix(int n);
      fill_kind_type kind;
      case ($urandom_range(0, 7))
         0:       kind = FillBelow;
         1, 2:    kind = FillTies;
         default: kind = FillWide;
      endcase
      repeat (n * n) send_score(draw_score(kind));
   endtask

   initial begin
      int n;
      int extra;
      int small_items;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single entry: top score, exactly -1.0 (never paired), just above -1.0
      set_size(1);
      send_score(16'sh7FFF);
      send_score(NegOne);
      send_score(NegOne + 1);
      // all-equal scores, then one row that cannot be paired
      set_size(2);
      repeat (4) send_score(5);
      send_score(-32768);
      send_score(NegOne);
      send_score(NegOne - 1);
      send_score(100);
      // zero size: scores are dropped
      set_size(0);
      send_score(1);
      send_score(-1);
      // shrink the size part way through a load
      set_size(16);
      send_score(7);
      send_score(7);
      send_score(9);
      set_size(2);
      send_score(3);
      set_size(3);
      send_score(-100);
      send_score(200);
      send_score(200);
      send_score(NegOne);
      send_score(0);
      set_size(2);
      send_score(1);

      // full matrix with the register above the maximum, upper data bits set
      set_size(32'hFFFF_FFFF);
      send_matrix(MaxSize);

      // stall the result side long enough for the block to back up its input
      set_size(1);
      hold_off_request = 1'b1;
      repeat (10) send_score(draw_score(FillWide));

      // closing stretch of small matrices with no idling on either side
      calm        = 1'b1;
      small_items = 0;
      while (small_items < 12) begin
         if ($urandom_range(0, 9) == 0) begin
            set_size(0);
            repeat ($urandom_range(1, 4)) send_score(draw_score(FillWide));
         end else begin
            n = $urandom_range(1, 4);
            set_size(n);
            repeat ($urandom_range(1, 2)) begin
               send_matrix(n);
               small_items += n * n;
            end
            // leave a part-loaded matrix for the next size to pick up
            if (n > 1 && $urandom_range(0, 3) == 0) begin
               extra = $urandom_range(1, n * n - 1);
               repeat (extra) send_score(draw_score(FillWide));
               small_items += extra;
            end
         end
      end

      wait_idle();
      $display("run: %0d scores accepted, %0d result words checked, %0d size writes",
               board.taken, board.seen, size_writes);
      $display("run: sizes 0 to 16 and oversized, ties, unpaired rows, mid-load resizes");
      if (board.errors == 0)
         $display("greedy_max_assignment: match");
      else
         $display("greedy_max_assignment: mismatch");
      $finish;
   end

endmodule

>>> filelist.f
src/gma_pkg.sv
src/gma_ram.sv
src/gma_fifo.sv
src/gma_front.sv
src/gma_back.sv
src/greedy_max_assignment.sv
src/gma_checker.sv
tb/greedy_max_assignment_test.sv
